>>> rtl/core/dpsq_pkg.sv
// Package for the dual policy service queue.
// Entry type, request codes, status codes and controller states.
// No dependencies.
`timescale 1ns / 1ps

package dpsq_pkg;

   localparam logic [1:0] FN_ARRIVE       = 2'd0;
   localparam logic [1:0] FN_SERVE_OLDEST = 2'd1;
   localparam logic [1:0] FN_SERVE_VALUE  = 2'd2;

   localparam logic [1:0] STS_ACCEPTED = 2'd0;
   localparam logic [1:0] STS_SERVED   = 2'd1;
   localparam logic [1:0] STS_EMPTY    = 2'd2;
   localparam logic [1:0] STS_REJECT   = 2'd3;

   typedef struct packed {
      logic        valid;
      logic [31:0] value;
      logic [31:0] number;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

>>> rtl/core/dpsq_cell.sv
// One storage cell of the circulating entry ring.
// Depends on dpsq_pkg (entry_type).
`timescale 1ns / 1ps

module dpsq_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  dpsq_pkg::entry_type ent_i,
   output dpsq_pkg::entry_type ent_o
);

   logic        valid_ff;
   logic [31:0] value_ff;
   logic [31:0] number_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= ent_i.valid;
      end
   end

   // payload needs no reset; only valid entries are ever used
   always_ff @(posedge clock) begin
      if (shift) begin
         value_ff  <= ent_i.value;
         number_ff <= ent_i.number;
      end
   end

   assign ent_o = '{valid: valid_ff, value: value_ff, number: number_ff};

endmodule

>>> rtl/core/dual_policy_service_queue.sv
// Top level of the dual policy service queue.
// Depends on dpsq_pkg and dpsq_cell.
`timescale 1ns / 1ps

// Waiting table of CAPACITY entries held in a ring of cells. Each item is
// an arrival (func 0), a serve-oldest (func 1) or a serve-highest-value
// (func 2) request and yields one result item with a status and, for a
// serve, the removed entry's arrival number. Serves that find the table
// empty, full-table or exhausted-number arrivals and unknown codes need no
// table access and go straight to the done state. An arrival into a
// non-full table and a serve of a non-empty table rotate the whole ring
// once through the head logic. During a serve rotation the head keeps
// the best entry seen so far and swaps it against each better one, so
// the ring comes back without the winner.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted. Reset clears all valid marks
// at once; no clearing pass.
module dual_policy_service_queue #(
   parameter int CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_served_number,
   output logic [1:0]  rsp_status
);

   localparam int CW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] LAST = CW'(CAPACITY - 1);
   localparam logic [OW-1:0] FULL = OW'(CAPACITY);

   dpsq_pkg::state_type state_ff, state_in;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [31:0]   next_num_ff, next_num_in;
   logic          by_value_ff, by_value_in;    // serve by value, else oldest
   logic          arrive_ff, arrive_in;        // rotation places a new entry
   logic          placed_ff, placed_in;
   logic [31:0]   new_value_ff, new_value_in;
   dpsq_pkg::entry_type held_ff, held_in;
   logic [31:0]   pend_num_ff, pend_num_in;
   logic [1:0]    pend_sts_ff, pend_sts_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_num_ff, rsp_num_in;
   logic [1:0]    rsp_sts_ff, rsp_sts_in;

   logic                accept, out_free, scan_last, shift;
   logic                better;
   dpsq_pkg::entry_type head, back;
   dpsq_pkg::entry_type ring [CAPACITY];

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign shift    = (state_ff == dpsq_pkg::ST_SCAN);
   assign scan_last = shift && (cnt_ff == LAST);

   // ring of cells: cell 0 takes what the head logic hands back
   assign head = ring[CAPACITY-1];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      dpsq_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .ent_i ((i == 0) ? back : ring[(i == 0) ? 0 : i-1]),
         .ent_o (ring[i])
      );
   end

   // head compare: earlier arrival always has the smaller number
   always_comb begin
      if (!head.valid) begin
         better = 1'b0;
      end else if (!held_ff.valid) begin
         better = 1'b1;
      end else if (by_value_ff) begin
         better = (head.value > held_ff.value) ||
                  ((head.value == held_ff.value) && (head.number < held_ff.number));
      end else begin
         better = (head.number < held_ff.number);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dpsq_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_func == dpsq_pkg::FN_ARRIVE)
                  state_in = (occ_ff == FULL || next_num_ff == 32'd0) ?
                             dpsq_pkg::ST_DONE : dpsq_pkg::ST_SCAN;
               else if (req_func == dpsq_pkg::FN_SERVE_OLDEST ||
                        req_func == dpsq_pkg::FN_SERVE_VALUE)
                  state_in = (occ_ff == '0) ? dpsq_pkg::ST_DONE : dpsq_pkg::ST_SCAN;
               else
                  state_in = dpsq_pkg::ST_DONE;
            end
         end
         dpsq_pkg::ST_SCAN: begin
            if (scan_last) state_in = dpsq_pkg::ST_DONE;
         end
         dpsq_pkg::ST_DONE: begin
            if (out_free) state_in = dpsq_pkg::ST_IDLE;
         end
         default: state_in = dpsq_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready    = (state_ff == dpsq_pkg::ST_IDLE);
      cnt_in       = cnt_ff;
      occ_in       = occ_ff;
      next_num_in  = next_num_ff;
      by_value_in  = by_value_ff;
      arrive_in    = arrive_ff;
      placed_in    = placed_ff;
      new_value_in = new_value_ff;
      held_in      = held_ff;
      pend_num_in  = pend_num_ff;
      pend_sts_in  = pend_sts_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_num_in   = rsp_num_ff;
      rsp_sts_in   = rsp_sts_ff;
      back         = head;
      case (state_ff)
         dpsq_pkg::ST_IDLE: begin
            if (accept) begin
               cnt_in       = '0;
               by_value_in  = (req_func == dpsq_pkg::FN_SERVE_VALUE);
               arrive_in    = (req_func == dpsq_pkg::FN_ARRIVE);
               placed_in    = 1'b0;
               new_value_in = req_value;
               held_in.valid = 1'b0;
               pend_num_in  = 32'd0;
               case (req_func)
                  dpsq_pkg::FN_ARRIVE: begin
                     if (occ_ff == FULL || next_num_ff == 32'd0) begin
                        pend_sts_in = dpsq_pkg::STS_REJECT;
                     end else begin
                        pend_sts_in = dpsq_pkg::STS_ACCEPTED;
                        occ_in      = occ_ff + OW'(1);
                        next_num_in = next_num_ff + 32'd1;
                        held_in.number = next_num_ff;
                     end
                  end
                  dpsq_pkg::FN_SERVE_OLDEST, dpsq_pkg::FN_SERVE_VALUE: begin
                     pend_sts_in = (occ_ff == '0) ? dpsq_pkg::STS_EMPTY :
                                                    dpsq_pkg::STS_SERVED;
                  end
                  default: pend_sts_in = dpsq_pkg::STS_REJECT;
               endcase
            end
         end
         dpsq_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + CW'(1);
            if (arrive_ff) begin
               // first free cell takes the new entry; held carries its number
               if (!head.valid && !placed_ff) begin
                  back      = '{valid: 1'b1, value: new_value_ff, number: held_ff.number};
                  placed_in = 1'b1;
               end
            end else if (better) begin
               back    = held_ff;
               held_in = head;
            end
            if (scan_last && !arrive_ff) begin
               pend_num_in = better ? head.number : held_ff.number;
               occ_in      = occ_ff - OW'(1);
            end
         end
         dpsq_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = pend_num_ff;
               rsp_sts_in   = pend_sts_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dpsq_pkg::ST_IDLE;
         occ_ff       <= '0;
         next_num_ff  <= 32'd1;
         rsp_valid_ff <= 1'b0;
         held_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         next_num_ff  <= next_num_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      by_value_ff    <= by_value_in;
      arrive_ff      <= arrive_in;
      placed_ff      <= placed_in;
      new_value_ff   <= new_value_in;
      pend_num_ff    <= pend_num_in;
      pend_sts_ff    <= pend_sts_in;
      rsp_num_ff     <= rsp_num_in;
      rsp_sts_ff     <= rsp_sts_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_served_number = rsp_num_ff;
   assign rsp_status        = rsp_sts_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL) else $error("occupancy above capacity");

   a_served_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == dpsq_pkg::STS_SERVED |-> rsp_served_number != 32'd0)
      else $error("served item without arrival number");

   a_serve_found: assert property (@(posedge clock) disable iff (reset)
      scan_last && !arrive_ff |-> (held_ff.valid || head.valid))
      else $error("serve rotation found no entry");

   a_arrive_placed: assert property (@(posedge clock) disable iff (reset)
      scan_last && arrive_ff |=> placed_ff)
      else $error("arrival found no free cell");

endmodule
